[hdl/mcct_pkg.sv]
package mcct_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int WINDOW_HALF = 7;
  localparam int STORE_ROWS  = 2 * WINDOW_HALF;
  localparam int ENTRIES     = 4;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SIZE_W  = COL_W + 1;
  localparam int CNT_W   = 8;
  localparam int RAD_W   = 8;
  localparam int SLOT_W  = $clog2(STORE_ROWS);
  localparam int WIN_W   = $clog2(STORE_ROWS + 1);
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int RANK_W  = 2;
  localparam int KEY_W   = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int RECIP_SH = 16;
  localparam int RECIP    = (1 << RECIP_SH) / STORE_ROWS;

  localparam logic [CNT_W-1:0]        MIN_START     = CNT_W'(4 * WINDOW_HALF * WINDOW_HALF);
  localparam logic signed [KEY_W-1:0] KEY_MIN_START = KEY_W'(10000);
  localparam logic [RANK_W-1:0]       RANK_FIRST    = RANK_W'(0);
  localparam logic [RANK_W-1:0]       RANK_X_MINUS_Y = RANK_W'(1);
  localparam logic [RANK_W-1:0]       RANK_Y_MINUS_X = RANK_W'(3);
  localparam logic [RANK_W-1:0]       RANK_LAST     = RANK_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_BLACK_THRESHOLD,
    REG_MERGE_RADIUS
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_CHECK,
    S_JSTART,
    S_JREAD,
    S_JDRAIN,
    S_JUPD,
    S_PICK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic write;
    logic jstart;
    logic jissue;
    logic update;
    logic pick;
    logic rank_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic job_valid;
    logic frame_end;
    logic issue_last;
    logic rank_last;
  } sts_t;

  function automatic logic [SLOT_W-1:0] row_slot(input logic [ROW_W-1:0] r);
    logic [ROW_W+RECIP_SH-1:0] prod;
    logic [ROW_W-1:0]          q;
    logic [ROW_W-1:0]          rem;
    prod = (ROW_W+RECIP_SH)'(r) * (ROW_W+RECIP_SH)'(RECIP);
    q    = prod[ROW_W+RECIP_SH-1:RECIP_SH];
    rem  = r - ROW_W'(q * ROW_W'(STORE_ROWS));
    if (rem >= ROW_W'(STORE_ROWS)) begin
      rem = rem - ROW_W'(STORE_ROWS);
    end
    return SLOT_W'(rem);
  endfunction

  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W+1:0] v);
    logic [SLOT_W+1:0] t;
    t = v;
    if (t >= (SLOT_W+2)'(STORE_ROWS)) begin
      t = t - (SLOT_W+2)'(STORE_ROWS);
    end
    if (t >= (SLOT_W+2)'(STORE_ROWS)) begin
      t = t - (SLOT_W+2)'(STORE_ROWS);
    end
    return SLOT_W'(t);
  endfunction

endpackage

[hdl/mcct_ram.sv]
module mcct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/mcct_ctrl.sv]
module mcct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mcct_pkg::sts_t sts,
  output mcct_pkg::cmd_t cmd
);
  import mcct_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts.job_valid) begin
          state_nxt = S_JSTART;
        end else if (sts.frame_end) begin
          state_nxt = S_PICK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_JSTART: begin
        cmd.jstart = 1'b1;
        state_nxt  = S_JREAD;
      end
      S_JREAD: begin
        cmd.jissue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = S_JDRAIN;
        end
      end
      S_JDRAIN: begin
        state_nxt = S_JUPD;
      end
      S_JUPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.rank_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.rank_next = 1'b1;
            state_nxt     = S_PICK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/mcct_dp.sv]
module mcct_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mcct_pkg::cmd_t                 cmd,
  output mcct_pkg::sts_t                 sts,
  input  logic                           in_pixel_white,
  input  logic [mcct_pkg::SIZE_W-1:0]    w_eff,
  input  logic [mcct_pkg::SIZE_W-1:0]    h_eff,
  input  logic [mcct_pkg::CNT_W-1:0]     thr,
  input  logic [mcct_pkg::RAD_W-1:0]     rad,
  output logic [mcct_pkg::COL_W-1:0]     out_corner_x,
  output logic [mcct_pkg::ROW_W-1:0]     out_corner_y,
  output logic [mcct_pkg::CNT_W-1:0]     out_black_count,
  output logic [mcct_pkg::RANK_W-1:0]    out_corner_rank,
  output logic                           out_last_corner
);
  import mcct_pkg::*;

  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  c_r;
  logic [ROW_W-1:0]  r_r;
  logic              pix_r;

  logic              job_valid_r;
  logic              frame_end_r;
  logic              tail_r;
  logic [ROW_W-1:0]  jr_r;
  logic [COL_W-1:0]  jc_r;
  logic [COL_W-1:0]  jc_last_r;
  logic [SLOT_W-1:0] jr_slot_r;
  logic [WIN_W-1:0]  k_r;
  logic [WIN_W-1:0]  k_pend_r;
  logic              rd_pend_r;
  logic              col_ok_r;
  logic [CNT_W-1:0]  acc_r;
  logic              center_r;

  logic [CNT_W-1:0]  ent_cnt_r [ENTRIES];
  logic [COL_W-1:0]  ent_x_r [ENTRIES];
  logic [ROW_W-1:0]  ent_y_r [ENTRIES];
  logic [RANK_W-1:0] rank_r;
  logic [IDX_W-1:0]  idx_r;

  logic [COL_W-1:0]      c_clamp;
  logic [ROW_W-1:0]      r_clamp;
  logic [COL_W-1:0]      w_last;
  logic [ROW_W-1:0]      h_last;
  logic [COL_W-1:0]      tail_jc;
  logic [ROW_W-1:0]      tail_jr;
  logic                  last_col;
  logic                  last_row;
  logic [SLOT_W-1:0]     wslot;
  logic [STORE_ROWS-1:0] we_slot;
  logic [STORE_ROWS-1:0] rd_word;
  logic [STORE_ROWS-1:0] row_mask;
  logic signed [COL_W+1:0] jj;
  logic                  jj_ok;
  logic [COL_W-1:0]      raddr;

  logic                  match_found;
  logic [IDX_W-1:0]      match_idx;
  logic [CNT_W-1:0]      minv;
  logic [IDX_W-1:0]      min_idx;
  logic [IDX_W-1:0]      pick_idx;

  assign w_last  = COL_W'(w_eff - SIZE_W'(1));
  assign h_last  = ROW_W'(h_eff - SIZE_W'(1));
  assign c_clamp = ({1'b0, col_r} >= w_eff) ? w_last : col_r;
  assign r_clamp = ({1'b0, row_r} >= h_eff) ? h_last : row_r;
  assign last_col = (c_r == w_last);
  assign last_row = (r_r == h_last);
  assign tail_jr = (h_eff > SIZE_W'(WINDOW_HALF - 1)) ?
                   ROW_W'(h_eff - SIZE_W'(WINDOW_HALF - 1)) : '0;
  assign tail_jc = (w_eff > SIZE_W'(WINDOW_HALF)) ?
                   COL_W'(w_eff - SIZE_W'(WINDOW_HALF)) : '0;
  assign wslot   = row_slot(r_r);

  always_comb begin
    for (int s = 0; s < STORE_ROWS; s++) begin
      we_slot[s] = cmd.write && (wslot == SLOT_W'(s));
    end
  end

  assign jj    = $signed({2'b00, jc_r}) - $signed((COL_W+2)'(WINDOW_HALF))
               + $signed((COL_W+2)'(k_r));
  assign jj_ok = (jj >= 0) && (jj < $signed({1'b0, w_eff}));
  assign raddr = jj[COL_W-1:0];

  for (genvar s = 0; s < STORE_ROWS; s++) begin : g_store
    mcct_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (we_slot[s]),
      .waddr (c_r),
      .wdata (pix_r),
      .raddr (raddr),
      .rdata (rd_word[s])
    );
  end

  always_comb begin
    logic signed [ROW_W+1:0] ii;
    logic [SLOT_W-1:0]       sl;
    row_mask = '0;
    for (int k = 0; k < STORE_ROWS; k++) begin
      ii = $signed({2'b00, jr_r}) - $signed((ROW_W+2)'(WINDOW_HALF))
         + $signed((ROW_W+2)'(k));
      sl = wrap_slot((SLOT_W+2)'(jr_slot_r) + (SLOT_W+2)'(WINDOW_HALF + k));
      row_mask[sl] = (ii >= 0) && (ii < $signed({1'b0, h_eff}));
    end
  end

  always_comb begin
    logic signed [ROW_W+1:0] dy;
    logic signed [COL_W+1:0] dx;
    logic signed [ROW_W+1:0] ry;
    logic signed [COL_W+1:0] rx;
    ry = $signed((ROW_W+2)'(rad));
    rx = $signed((COL_W+2)'(rad));
    match_found = 1'b0;
    match_idx   = '0;
    minv        = MIN_START;
    min_idx     = '0;
    for (int e = 0; e < ENTRIES; e++) begin
      dy = $signed({2'b00, jr_r}) - $signed({2'b00, ent_y_r[e]});
      dx = $signed({2'b00, jc_r}) - $signed({2'b00, ent_x_r[e]});
      if (dy > -ry && dy < ry && dx > -rx && dx < rx) begin
        match_found = 1'b1;
        match_idx   = IDX_W'(e);
      end
      if (ent_cnt_r[e] < minv) begin
        minv    = ent_cnt_r[e];
        min_idx = IDX_W'(e);
      end
    end
  end

  always_comb begin
    logic signed [KEY_W-1:0] best;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] kx;
    logic signed [KEY_W-1:0] ky;
    pick_idx = idx_r;
    best     = (rank_r == RANK_FIRST) ? KEY_MIN_START : '0;
    for (int e = 0; e < ENTRIES; e++) begin
      kx = $signed(KEY_W'(ent_x_r[e]));
      ky = $signed(KEY_W'(ent_y_r[e]));
      unique case (rank_r)
        RANK_X_MINUS_Y: key = kx - ky;
        RANK_Y_MINUS_X: key = ky - kx;
        default:        key = kx + ky;
      endcase
      if (rank_r == RANK_FIRST) begin
        if (key < best) begin
          best     = key;
          pick_idx = IDX_W'(e);
        end
      end else if (key > best) begin
        best     = key;
        pick_idx = IDX_W'(e);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      job_valid_r <= 1'b0;
      frame_end_r <= 1'b0;
      tail_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      rank_r      <= RANK_FIRST;
      idx_r       <= '0;
      for (int e = 0; e < ENTRIES; e++) begin
        ent_cnt_r[e] <= '0;
        ent_x_r[e]   <= '0;
        ent_y_r[e]   <= '0;
      end
    end else begin
      rd_pend_r <= cmd.jissue;
      if (cmd.accept) begin
        pix_r <= in_pixel_white;
        c_r   <= c_clamp;
        r_r   <= r_clamp;
      end
      if (cmd.write) begin
        frame_end_r <= last_col && last_row;
        tail_r      <= 1'b0;
        job_valid_r <= 1'b0;
        if (r_r >= ROW_W'(WINDOW_HALF - 1)) begin
          jr_r <= r_r - ROW_W'(WINDOW_HALF - 1);
          if (!last_col) begin
            jc_r      <= c_r - COL_W'(WINDOW_HALF - 1);
            jc_last_r <= c_r - COL_W'(WINDOW_HALF - 1);
            job_valid_r <= (c_r >= COL_W'(WINDOW_HALF - 1));
          end else begin
            jc_r        <= tail_jc;
            jc_last_r   <= w_last;
            job_valid_r <= 1'b1;
          end
        end
        if (last_col && last_row && (r_r < ROW_W'(WINDOW_HALF - 1))) begin
          tail_r      <= 1'b1;
          job_valid_r <= 1'b1;
          jr_r        <= tail_jr;
          jc_r        <= '0;
          jc_last_r   <= w_last;
        end
        priority if (!last_col) begin
          col_r <= c_r + COL_W'(1);
          row_r <= r_r;
        end else if (!last_row) begin
          col_r <= '0;
          row_r <= r_r + ROW_W'(1);
        end else begin
          col_r <= '0;
          row_r <= '0;
        end
      end
      if (cmd.update) begin
        if (center_r && (acc_r > thr)) begin
          if (match_found) begin
            if (acc_r > ent_cnt_r[match_idx]) begin
              ent_cnt_r[match_idx] <= acc_r;
              ent_x_r[match_idx]   <= jc_r;
              ent_y_r[match_idx]   <= jr_r;
            end
          end else if (minv < acc_r) begin
            ent_cnt_r[min_idx] <= acc_r;
            ent_x_r[min_idx]   <= jc_r;
            ent_y_r[min_idx]   <= jr_r;
          end
        end
        priority if (jc_r != jc_last_r) begin
          jc_r <= jc_r + COL_W'(1);
        end else if (frame_end_r && !tail_r) begin
          tail_r    <= 1'b1;
          jr_r      <= tail_jr;
          jc_r      <= '0;
          jc_last_r <= w_last;
        end else if (tail_r && (jr_r != h_last)) begin
          jr_r <= jr_r + ROW_W'(1);
          jc_r <= '0;
        end else begin
          job_valid_r <= 1'b0;
        end
      end
      if (cmd.pick) begin
        idx_r <= pick_idx;
      end
      if (cmd.rank_next) begin
        rank_r <= rank_r + RANK_W'(1);
      end
      if (cmd.clear) begin
        rank_r      <= RANK_FIRST;
        idx_r       <= '0;
        frame_end_r <= 1'b0;
        for (int e = 0; e < ENTRIES; e++) begin
          ent_cnt_r[e] <= '0;
          ent_x_r[e]   <= '0;
          ent_y_r[e]   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.jstart) begin
      jr_slot_r <= row_slot(jr_r);
      k_r       <= '0;
      acc_r     <= '0;
    end else begin
      if (cmd.jissue) begin
        k_r <= k_r + WIN_W'(1);
      end
      if (rd_pend_r) begin
        if (col_ok_r) begin
          acc_r <= acc_r + CNT_W'($countones(~rd_word & row_mask));
        end
        if (k_pend_r == WIN_W'(WINDOW_HALF)) begin
          center_r <= rd_word[jr_slot_r];
        end
      end
    end
    if (cmd.jissue) begin
      k_pend_r <= k_r;
      col_ok_r <= jj_ok;
    end
    if (cmd.pick) begin
      out_corner_x    <= ent_x_r[pick_idx];
      out_corner_y    <= ent_y_r[pick_idx];
      out_black_count <= ent_cnt_r[pick_idx];
      out_corner_rank <= rank_r;
      out_last_corner <= (rank_r == RANK_LAST);
    end
  end

  assign sts.job_valid  = job_valid_r;
  assign sts.frame_end  = frame_end_r;
  assign sts.issue_last = (k_r == WIN_W'(STORE_ROWS - 1));
  assign sts.rank_last  = (rank_r == RANK_LAST);

endmodule

[hdl/mask_corner_candidate_tracker.sv]
// Corner candidate tracker for a binary mask frame.
// in_pixel_white carries one mask pixel per beat in raster order; the frame
// size comes from the frame_width and frame_height registers on the APB port.
// Each beat is written into a 14-row line store, then every pixel whose
// 14x14 window completed is judged: the window is read one column per cycle
// from the line store. A beat at a row end judges up to 7 pixels.
// On the last beat of a frame the remaining 6 rows are judged (6*width pixels)
// and four corner beats follow on the out_ channel, ranked 0 to 3, with
// out_last_corner high on the fourth; the corner table then clears.
// The block holds a corner beat while the receiver stalls and accepts no pixel.
// in_ready is high only while the block waits for a pixel.
// Reset (rst_n low, synchronous) clears the corner table, the pixel position
// and the registers to 640x480, threshold 98, radius 30. The line store is not
// cleared; every location read within a frame is written earlier in it.
module mask_corner_candidate_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_pixel_white,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcct_pkg::COL_W-1:0]    out_corner_x,
  output logic [mcct_pkg::ROW_W-1:0]    out_corner_y,
  output logic [mcct_pkg::CNT_W-1:0]    out_black_count,
  output logic [mcct_pkg::RANK_W-1:0]   out_corner_rank,
  output logic                          out_last_corner,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcct_pkg::ADDR_W-1:0]   paddr,
  input  logic [mcct_pkg::DATA_W-1:0]   pwdata,
  output logic [mcct_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import mcct_pkg::*;

  logic [SIZE_W-1:0] frame_width_r;
  logic [SIZE_W-1:0] frame_height_r;
  logic [CNT_W-1:0]  black_threshold_r;
  logic [RAD_W-1:0]  merge_radius_r;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  reg_idx_t          reg_idx;
  logic              reg_we;
  cmd_t              cmd;
  sts_t              sts;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign reg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r     <= SIZE_W'(640);
      frame_height_r    <= SIZE_W'(480);
      black_threshold_r <= CNT_W'(98);
      merge_radius_r    <= RAD_W'(30);
    end else if (reg_we) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:     frame_width_r     <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:    frame_height_r    <= pwdata[SIZE_W-1:0];
        REG_BLACK_THRESHOLD: black_threshold_r <= pwdata[CNT_W-1:0];
        REG_MERGE_RADIUS:    merge_radius_r    <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:     prdata = DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT:    prdata = DATA_W'(frame_height_r);
      REG_BLACK_THRESHOLD: prdata = DATA_W'(black_threshold_r);
      REG_MERGE_RADIUS:    prdata = DATA_W'(merge_radius_r);
      default:             prdata = '0;
    endcase
  end

  assign w_eff = (frame_width_r == '0) ? SIZE_W'(1) :
                 (frame_width_r > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : frame_width_r;
  assign h_eff = (frame_height_r == '0) ? SIZE_W'(1) :
                 (frame_height_r > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : frame_height_r;

  mcct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcct_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_pixel_white  (in_pixel_white),
    .w_eff           (w_eff),
    .h_eff           (h_eff),
    .thr             (black_threshold_r),
    .rad             (merge_radius_r),
    .out_corner_x    (out_corner_x),
    .out_corner_y    (out_corner_y),
    .out_black_count (out_black_count),
    .out_corner_rank (out_corner_rank),
    .out_last_corner (out_last_corner)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("pixel intake open while a corner beat is pending");

  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_corner == (out_corner_rank == RANK_LAST)))
    else $error("last corner flag disagrees with rank");

  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_corner) |=> in_ready)
    else $error("block not idle after last corner");

  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_corner) |=> ##1
      (out_valid && out_corner_rank == $past(out_corner_rank, 2) + RANK_W'(1)))
    else $error("corner ranks out of sequence");
`endif

endmodule
